/* hw/rtl/crdf_pkg.sv */
package crdf_pkg;

   // Field widths.
   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int SCALE_W  = 20;
   localparam int LEN_W    = 17;
   localparam int WORD_W   = 32;

   // Default depth of the delay store.
   localparam int MAX_DELAY_DEFAULT = 65536;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN_COEF       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INPUT_SCALE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_LENGTH    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_POLARITY = 2'd3;

   localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 16'sd0;
   localparam logic [SCALE_W-1:0]       SCALE_RESET = 20'd32768;
   localparam logic [LEN_W-1:0]         LEN_RESET   = 17'd1;

   // Result queue.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       clipped;
   } result_type;

endpackage

/* hw/rtl/crdf_req_if.sv */
interface crdf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [crdf_pkg::SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

/* hw/rtl/crdf_rsp_if.sv */
interface crdf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [crdf_pkg::SAMPLE_W-1:0] sample_out;
   logic                                 clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

/* hw/rtl/crdf_ram.sv */
module crdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/comb_reverb_delay_filter.sv */
// Feedback comb filter for reverb on a circular delay line of MAX_DELAY 32-bit words
// (Q23.8). Each request beat carries one signed 24-bit sample; each response beat
// returns the output sample, stored word minus the sample (plus when invert_polarity
// is set), and a clipped flag that is set when the output or the written-back word
// saturated. The stored word is replaced by stored*gain_coef plus or minus
// sample*input_scale, rounded toward zero. The block takes one sample per clock cycle
// while its four-entry response queue has room for it, and returns each result through
// that queue. The rate is set by the single read-modify-write of the delay memory
// per sample: with an effective delay of one sample, every sample reads the word the
// previous one writes, and the block then takes a new sample only once the previous
// one has left stage 1. The store reads as zero after reset with no clearing pass: a
// fill mark records how far the circular position has written, so the block is ready
// as soon as reset is released. Feed zero samples to obtain the decay tail. Write the
// configuration only while no results are pending.
module comb_reverb_delay_filter #(
   parameter int MAX_DELAY = crdf_pkg::MAX_DELAY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   crdf_req_if.sink                           req_bus,
   crdf_rsp_if.source                         rsp_bus,
   input  logic                               csr_write_en,
   input  logic [crdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [crdf_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AddrW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int FillW = AddrW + 1;
   localparam int CmpW  = (FillW > crdf_pkg::LEN_W) ? FillW : crdf_pkg::LEN_W;
   localparam logic [CmpW-1:0]  MaxLen  = CmpW'(MAX_DELAY);
   localparam logic [AddrW-1:0] LastIdx = AddrW'(MAX_DELAY - 1);
   localparam logic [FillW-1:0] MaxFill = FillW'(MAX_DELAY);

   localparam int SW = crdf_pkg::SAMPLE_W;
   localparam int WW = crdf_pkg::WORD_W;
   localparam int GW = crdf_pkg::GAIN_W;
   localparam int PgW = WW + GW;                  // stored * gain
   localparam int PxW = SW + crdf_pkg::SCALE_W + 1; // sample * scale
   localparam int OsW = WW + 1;                   // stored -/+ sample*256
   localparam int WsW = PxW + 9;                  // full update sum

   localparam logic signed [WsW-1:0] WMax = WsW'(64'sd2147483647);
   localparam logic signed [WsW-1:0] WMin = WsW'(-64'sd2147483648);
   localparam logic signed [OsW-1:0] OMax = OsW'(64'sd8388607);
   localparam logic signed [OsW-1:0] OMin = OsW'(-64'sd8388608);

   // Configuration registers.
   logic signed [GW-1:0]                  gain_ff;
   logic [crdf_pkg::SCALE_W-1:0]          scale_ff;
   logic [crdf_pkg::LEN_W-1:0]            len_ff;
   logic                                  invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= crdf_pkg::GAIN_RESET;
         scale_ff  <= crdf_pkg::SCALE_RESET;
         len_ff    <= crdf_pkg::LEN_RESET;
         invert_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            crdf_pkg::REG_GAIN_COEF:       gain_ff   <= signed'(csr_data[GW-1:0]);
            crdf_pkg::REG_INPUT_SCALE:     scale_ff  <= csr_data[crdf_pkg::SCALE_W-1:0];
            crdf_pkg::REG_DELAY_LENGTH:    len_ff    <= csr_data[crdf_pkg::LEN_W-1:0];
            crdf_pkg::REG_INVERT_POLARITY: invert_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Circular position. The next address is worked out from the current position and
   // the effective length, which clamps zero up to one and long delays to MAX_DELAY.
   logic [AddrW-1:0] pos_ff, pos_in;
   logic [CmpW-1:0]  len_eff;
   logic [CmpW-1:0]  pos_inc;
   logic [AddrW-1:0] next_addr;

   always_comb begin
      if (CmpW'(len_ff) == '0) begin
         len_eff = CmpW'(1);
      end else if (CmpW'(len_ff) > MaxLen) begin
         len_eff = MaxLen;
      end else begin
         len_eff = CmpW'(len_ff);
      end
      pos_inc = CmpW'(pos_ff) + CmpW'(1);
      if (pos_inc >= len_eff) begin
         next_addr = '0;
      end else begin
         next_addr = pos_inc[AddrW-1:0];
      end
   end

   // Pipeline valid bits and the response queue count, needed for flow control.
   logic                               s1_valid_ff, s2_valid_ff;
   logic [AddrW-1:0]                   s1_addr_ff, s2_addr_ff;
   logic [crdf_pkg::OUT_CNT_W-1:0]     count_ff, count_in;
   logic [crdf_pkg::OUT_CNT_W:0]       pending;
   logic                               hazard;
   logic                               accept;

   // A sample may not read the word that the sample one stage ahead has yet to
   // compute. Only an effective delay of one sample produces that case. A word that
   // is written in the cycle of the read is covered by the forwarding register.
   assign hazard  = s1_valid_ff && (next_addr == s1_addr_ff);
   assign pending = (crdf_pkg::OUT_CNT_W + 1)'(count_ff)
                  + (crdf_pkg::OUT_CNT_W + 1)'(s1_valid_ff)
                  + (crdf_pkg::OUT_CNT_W + 1)'(s2_valid_ff);
   assign req_bus.ready = !hazard && (pending < (crdf_pkg::OUT_CNT_W + 1)'(crdf_pkg::OUT_DEPTH));
   assign accept = req_bus.valid && req_bus.ready;
   assign pos_in = accept ? next_addr : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= LastIdx;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Delay memory.
   logic [WW-1:0]  ram_rd_data;
   logic           wr_en;
   logic [WW-1:0]  wr_data;

   crdf_ram #(
      .WIDTH(WW),
      .DEPTH(MAX_DELAY)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_addr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (next_addr),
      .rd_data (ram_rd_data)
   );

   // Stage 1: pick the stored word, form the output sum and both products.
   logic signed [SW-1:0]  s1_x_ff;
   logic [FillW-1:0]      fill_ff, fill_in;
   logic                  fwd_valid_ff;
   logic [AddrW-1:0]      fwd_addr_ff;
   logic [WW-1:0]         fwd_data_ff;
   logic signed [WW-1:0]  stored;
   logic signed [WW-1:0]  x_q8;
   logic signed [OsW-1:0] osum_in;
   logic signed [PgW-1:0] pg_in;
   logic signed [PxW-1:0] px_in;
   logic signed [crdf_pkg::SCALE_W:0] scale_s;

   always_comb begin
      // The last write wins over the memory; words at or beyond the fill mark were never
      // written since reset and read as zero.
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         stored = signed'(fwd_data_ff);
      end else if ({1'b0, s1_addr_ff} >= fill_ff) begin
         stored = '0;
      end else begin
         stored = signed'(ram_rd_data);
      end
      x_q8    = signed'({s1_x_ff, 8'b0});
      if (invert_ff) begin
         osum_in = OsW'(stored) + OsW'(x_q8);
      end else begin
         osum_in = OsW'(stored) - OsW'(x_q8);
      end
      scale_s = signed'({1'b0, scale_ff});
      pg_in   = PgW'(stored) * PgW'(gain_ff);
      px_in   = PxW'(s1_x_ff) * PxW'(scale_s);
   end

   logic signed [OsW-1:0] s2_osum_ff;
   logic signed [PgW-1:0] s2_pg_ff;
   logic signed [PxW-1:0] s2_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_addr_ff <= next_addr;
      s1_x_ff    <= req_bus.sample_in;
      s2_addr_ff <= s1_addr_ff;
      s2_osum_ff <= osum_in;
      s2_pg_ff   <= pg_in;
      s2_px_ff   <= px_in;
   end

   // Stage 2: sum the update, round both values toward zero and saturate.
   logic signed [WsW-1:0] wsum;
   logic signed [WsW-1:0] wq;
   logic signed [OsW-1:0] oq;
   logic signed [WW-1:0]  w_sat;
   logic signed [SW-1:0]  o_sat;
   logic                  sat_w, sat_o;

   always_comb begin
      if (invert_ff) begin
         wsum = WsW'(s2_pg_ff) - WsW'(signed'({s2_px_ff, 8'b0}));
      end else begin
         wsum = WsW'(s2_pg_ff) + WsW'(signed'({s2_px_ff, 8'b0}));
      end
      wq = wsum >>> 15;
      if (wsum[WsW-1] && (wsum[14:0] != '0)) begin
         wq = wq + WsW'(1);
      end
      sat_w = 1'b0;
      if (wq > WMax) begin
         w_sat = WW'(WMax);
         sat_w = 1'b1;
      end else if (wq < WMin) begin
         w_sat = WW'(WMin);
         sat_w = 1'b1;
      end else begin
         w_sat = wq[WW-1:0];
      end

      oq = s2_osum_ff >>> 8;
      if (s2_osum_ff[OsW-1] && (s2_osum_ff[7:0] != '0)) begin
         oq = oq + OsW'(1);
      end
      sat_o = 1'b0;
      if (oq > OMax) begin
         o_sat = SW'(OMax);
         sat_o = 1'b1;
      end else if (oq < OMin) begin
         o_sat = SW'(OMin);
         sat_o = 1'b1;
      end else begin
         o_sat = oq[SW-1:0];
      end
   end

   assign wr_en   = s2_valid_ff;
   assign wr_data = w_sat;

   // The fill mark only grows: the position steps by one or returns to zero, so the
   // written words always form a prefix of the store.
   always_comb begin
      fill_in = fill_ff;
      if (wr_en && ({1'b0, s2_addr_ff} >= fill_ff)) begin
         fill_in = {1'b0, s2_addr_ff} + FillW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
      if (wr_en) begin
         fwd_addr_ff <= s2_addr_ff;
         fwd_data_ff <= w_sat;
      end
   end

   // Response queue. Room for every sample in flight is reserved at the request beat,
   // so a push always finds a free entry.
   crdf_pkg::result_type           queue_ff [crdf_pkg::OUT_DEPTH];
   logic [crdf_pkg::OUT_PTR_W-1:0] wptr_ff, rptr_ff;
   logic                           push, pop;

   assign push = s2_valid_ff;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + crdf_pkg::OUT_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - crdf_pkg::OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= wptr_ff + crdf_pkg::OUT_PTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + crdf_pkg::OUT_PTR_W'(1);
         end
      end
      if (push) begin
         queue_ff[wptr_ff].sample_out <= o_sat;
         queue_ff[wptr_ff].clipped    <= sat_o || sat_w;
      end
   end

   assign rsp_bus.valid      = (count_ff != '0);
   assign rsp_bus.sample_out = queue_ff[rptr_ff].sample_out;
   assign rsp_bus.clipped    = queue_ff[rptr_ff].clipped;

   // A new sample never reads the word that stage 1 has not yet updated.
   a_no_raw_overlap: assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff |-> next_addr != s1_addr_ff)
      else $error("sample accepted on a word still being updated");

   // The queue never receives a result without a free entry.
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < crdf_pkg::OUT_CNT_W'(crdf_pkg::OUT_DEPTH)) || pop)
      else $error("response queue overflow");

   // Writes past the fill mark extend it by exactly one word.
   a_fill_prefix: assert property (@(posedge clock) disable iff (reset)
      wr_en && ({1'b0, s2_addr_ff} >= fill_ff) |-> {1'b0, s2_addr_ff} == fill_ff)
      else $error("write leaves a gap beyond the fill mark");

   // The fill mark stays within the store.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MaxFill)
      else $error("fill mark beyond the store depth");

endmodule
